// ===== rtl/sorted_key_table_macros.svh =====
// ----------------------------------------------------------------------------
// sorted_key_table_macros: assertion macros for the sorted key table
// Each macro expects clk and rst to be visible where it is used.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define SKT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/skt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  // Request modes
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_DUMP   = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY     = 3'd4;
  localparam logic [2:0] ST_LISTED    = 3'd5;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
    logic [4:0]         entry_count;
    logic               last;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;    // capture request and compare vectors
    logic apply;       // update table and load insert/delete result
    logic dump_emit;   // load head entry as a listed result
    logic dump_empty;  // load the empty dump result
    logic rotate;      // rotate the cell row by one place
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] in_mode;         // mode of the offered request
    logic       count_zero;
    logic       rot_last_entry;  // head cell holds the last stored key
    logic       rot_end;         // next rotation restores the row
    logic       space;           // output register can take a result
  } stat_t;

endpackage

// ===== rtl/skt_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_dpath
// Row of key cells with per-cell comparators, shift paths for insert and
// delete, a rotating read-out for dumps and the output register.
// ----------------------------------------------------------------------------
module skt_dpath #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  skt_pkg::req_t  req,
  input  skt_pkg::cmd_t  cmd,
  output skt_pkg::stat_t stat,
  input  logic           rsp_ready,
  output logic           rsp_valid,
  output skt_pkg::rsp_t  rsp
);
  import skt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  req_t                req_q;
  logic signed [31:0]  cells [CAPACITY];
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  logic [CW-1:0]       rot;
  logic [CAPACITY-1:0] lt;
  logic [CAPACITY-1:0] eq;
  logic [CAPACITY-1:0] cmp_lt;
  logic [CAPACITY-1:0] cmp_eq;
  logic                full;
  logic                found;
  logic                do_insert;
  logic                do_delete;
  logic                load;
  rsp_t                res;
  rsp_t                rsp_q;
  logic                out_valid;

  // Compare every stored key with the offered key
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cmp_lt[i] = (count > CW'(i)) && (cells[i] < req.key);
      cmp_eq[i] = (count > CW'(i)) && (cells[i] == req.key);
    end
  end

  // Capture request and compare vectors on accept
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q <= req;
      lt    <= cmp_lt;
      eq    <= cmp_eq;
    end
  end

  assign full      = (count == CW'(CAPACITY));
  assign found     = |eq;
  assign do_insert = (req_q.mode == MODE_INSERT) && !full;
  assign do_delete = (req_q.mode == MODE_DELETE) && (count != '0) && found;

  // Build the insert or delete result
  always_comb begin
    res.status = ST_INSERTED;
    res.value  = req_q.key;
    res.last   = 1'b1;
    count_next = count;
    unique case (req_q.mode)
      MODE_INSERT: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          count_next = CW'(count + 1'b1);
        end
      end
      MODE_DELETE: begin
        if (count == '0) begin
          res.status = ST_EMPTY;
        end else if (found) begin
          res.status = ST_DELETED;
          count_next = CW'(count - 1'b1);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        res.status = ST_INSERTED;
      end
    endcase
    res.entry_count = 5'(count_next);
  end

  // Cell row: hold, shift in, shift out or rotate
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [31:0] ins_val;
    logic signed [31:0] del_val;
    logic signed [31:0] rot_val;

    if (g == 0) begin : g_head
      assign ins_val = lt[g] ? cells[g] : req_q.key;
    end else begin : g_body
      assign ins_val = lt[g] ? cells[g] : (lt[g-1] ? req_q.key : cells[g-1]);
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign del_val = cells[g];
    end else begin : g_inner
      assign del_val = lt[g] ? cells[g] : cells[g+1];
    end

    assign rot_val = cells[(g + 1) % CAPACITY];

    always_ff @(posedge clk) begin
      if (cmd.apply && do_insert) begin
        cells[g] <= ins_val;
      end else if (cmd.apply && do_delete) begin
        cells[g] <= del_val;
      end else if (cmd.rotate) begin
        cells[g] <= rot_val;
      end
    end
  end

  // Entry count and rotation position
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rot   <= '0;
    end else begin
      if (cmd.apply) begin
        count <= count_next;
      end
      if (cmd.rotate) begin
        rot <= (rot == CW'(CAPACITY - 1)) ? '0 : CW'(rot + 1'b1);
      end
    end
  end

  // Output register
  assign load = cmd.apply || cmd.dump_emit || cmd.dump_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      rsp_q <= res;
    end else if (cmd.dump_emit) begin
      rsp_q.status      <= ST_LISTED;
      rsp_q.value       <= cells[0];
      rsp_q.entry_count <= 5'(count);
      rsp_q.last        <= stat.rot_last_entry;
    end else if (cmd.dump_empty) begin
      rsp_q.status      <= ST_EMPTY;
      rsp_q.value       <= '0;
      rsp_q.entry_count <= '0;
      rsp_q.last        <= 1'b1;
    end
  end

  assign rsp_valid = out_valid;
  assign rsp       = rsp_q;

  // Status to the controller
  assign stat.in_mode        = req.mode;
  assign stat.count_zero     = (count == '0);
  assign stat.rot_last_entry = (CW'(rot + 1'b1) == count);
  assign stat.rot_end        = (rot == CW'(CAPACITY - 1));
  assign stat.space          = !out_valid || rsp_ready;

endmodule

// ===== rtl/skt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer for the sorted key table: accepts a request, then applies it,
// walks the cell row for a dump, or drops it for the unused mode.
// ----------------------------------------------------------------------------
module skt_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  skt_pkg::stat_t stat,
  output skt_pkg::cmd_t  cmd
);
  import skt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RES,
    S_DUMP,
    S_SPIN
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load_req = 1'b1;
          if (stat.in_mode == MODE_DUMP) begin
            state_next = S_DUMP;
          end else if (stat.in_mode == MODE_INSERT || stat.in_mode == MODE_DELETE) begin
            state_next = S_RES;
          end
        end
      end
      S_RES: begin
        if (stat.space) begin
          cmd.apply  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_DUMP: begin
        if (stat.space) begin
          if (stat.count_zero) begin
            cmd.dump_empty = 1'b1;
            state_next     = S_IDLE;
          end else begin
            cmd.dump_emit = 1'b1;
            cmd.rotate    = 1'b1;
            if (stat.rot_last_entry) begin
              state_next = stat.rot_end ? S_IDLE : S_SPIN;
            end
          end
        end
      end
      S_SPIN: begin
        // advance the row back to its home position
        cmd.rotate = 1'b1;
        if (stat.rot_end) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Hold state and the registered ready
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      req_ready <= 1'b1;
    end else begin
      state     <= state_next;
      req_ready <= (state_next == S_IDLE);
    end
  end

endmodule

// ===== rtl/sorted_key_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table
// Table of up to CAPACITY signed keys kept in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   The req channel carries a mode and a key; the rsp channel returns
//   status, value, entry count and a last flag, both valid/ready.
//   Insert places the key ahead of equal keys, delete removes the first
//   equal key, dump lists every stored key in order with last on the final.
//   Insert and delete run as an accept, which registers the compare of
//   every cell against the key, then an update that shifts the cells and
//   loads the single result once the output register has space.
//   A dump emits one stored key per cycle from the head cell while rotating
//   the row, as long as the output register has space, then keeps rotating
//   until the row is home again; an empty table gives the empty result.
//   Mode 3 is accepted and dropped without a result.
//   A new request is taken while the last result still waits in the
//   output register; a stalled receiver holds that register and halts the
//   update or dump until space frees.
//   Reset empties the table (count zero); the cells themselves are not
//   cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`include "sorted_key_table_macros.svh"

module sorted_key_table #(
  parameter int unsigned CAPACITY = skt_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  skt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output skt_pkg::rsp_t rsp
);
  import skt_pkg::*;

  cmd_t       cmd;
  stat_t      stat;
  logic [2:0] loads;
  logic       load_any;

  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_ready (rsp_ready),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  // Result loads seen by the checks
  assign loads    = {cmd.apply, cmd.dump_emit, cmd.dump_empty};
  assign load_any = |loads;

  // Checks
  `SKT_ASSERT_NOW(a_one_load, 1'b1, $onehot0(loads), "more than one result load")
  `SKT_ASSERT_NOW(a_load_space, load_any, stat.space, "result loaded over a waiting result")
  `SKT_ASSERT_NOW(a_accept_no_load, req_valid && req_ready, !load_any, "result loaded on accept")
  `SKT_ASSERT_NOW(a_idle_no_rotate, req_ready, !cmd.rotate, "row rotated while idle")

endmodule

// ===== bench/sorted_key_table_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_tb
// Self-checking bench for the sorted key table. A directed table covers the
// empty, full, duplicate and extreme-key cases, and the unused mode. Random
// fill, drain and mixed phases follow. A shadow copy of the table predicts
// every result. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module sorted_key_table_tb;
  import skt_pkg::*;

  localparam int unsigned CAPACITY     = CAPACITY_DEF;
  localparam int          RANDOM_ITEMS = 225;
  localparam int          DRAIN_CYCLES = 2 * CAPACITY + 8;

  localparam logic [1:0]         MODE_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX     = 32'sh7FFF_FFFF;

  localparam int PHASE_FILL  = 0;
  localparam int PHASE_DRAIN = 1;
  localparam int PHASE_MIXED = 2;

  localparam int NUM_ROWS = 25;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] key;
    int                 reps;    // repeat with key + 0, 1, 2, ...
    bit                 typed;   // expected result written into the row
    logic [2:0]         status;
    logic [4:0]         count;
  } stim_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // Shadow copy of the table and the results still owed by the block
  logic signed [31:0] shadow_keys [CAPACITY];
  int                 shadow_count;
  rsp_t               expected_rsps [$];

  int        mismatch_count;
  bit        calm;
  stim_row_t stim_rows [NUM_ROWS];

  sorted_key_table #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up long after the slowest correct run would have ended
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic rsp_t make_rsp(logic [2:0] status, logic signed [31:0] value,
                                    int count, logic last);
    rsp_t o;
    o.status      = status;
    o.value       = value;
    o.entry_count = 5'(count);
    o.last        = last;
    return o;
  endfunction

  // Apply one request to the shadow table and queue the results it causes
  function automatic void apply_to_shadow(req_t r);
    int pos;
    case (r.mode)
      MODE_INSERT: begin
        if (shadow_count >= CAPACITY) begin
          expected_rsps.push_back(make_rsp(ST_FULL, r.key, shadow_count, 1'b1));
        end else begin
          // Land ahead of every equal key
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] < r.key) pos++;
          for (int i = shadow_count; i > pos; i--) shadow_keys[i] = shadow_keys[i - 1];
          shadow_keys[pos] = r.key;
          shadow_count++;
          expected_rsps.push_back(make_rsp(ST_INSERTED, r.key, shadow_count, 1'b1));
        end
      end
      MODE_DELETE: begin
        if (shadow_count == 0) begin
          expected_rsps.push_back(make_rsp(ST_EMPTY, r.key, 0, 1'b1));
        end else begin
          pos = 0;
          while (pos < shadow_count && shadow_keys[pos] != r.key) pos++;
          if (pos == shadow_count) begin
            expected_rsps.push_back(make_rsp(ST_NOT_FOUND, r.key, shadow_count, 1'b1));
          end else begin
            for (int i = pos; i + 1 < shadow_count; i++) shadow_keys[i] = shadow_keys[i + 1];
            shadow_count--;
            expected_rsps.push_back(make_rsp(ST_DELETED, r.key, shadow_count, 1'b1));
          end
        end
      end
      MODE_DUMP: begin
        if (shadow_count == 0) begin
          expected_rsps.push_back(make_rsp(ST_EMPTY, 32'sd0, 0, 1'b1));
        end else begin
          for (int i = 0; i < shadow_count; i++) begin
            expected_rsps.push_back(make_rsp(ST_LISTED, shadow_keys[i], shadow_count,
                                             logic'(i + 1 == shadow_count)));
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int draw_wait();
    if (calm) return 0;
    return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : $urandom_range(0, 3);
  endfunction

  // Mostly a narrow band around zero so that duplicates pile up
  function automatic logic signed [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 32'($signed($urandom_range(0, 8)) - 4);
    if (roll < 65) begin
      case ($urandom_range(0, 5))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return KEY_MIN + 1;
        3: return KEY_MAX - 1;
        4: return 32'sd0;
        default: return -32'sd1;
      endcase
    end
    return $urandom;
  endfunction

  // Delete mostly keys that are present
  function automatic logic signed [31:0] pick_stored_key();
    if (shadow_count > 0 && $urandom_range(0, 3) != 0)
      return shadow_keys[$urandom_range(0, shadow_count - 1)];
    return pick_key();
  endfunction

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 40) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Offer one request from a falling edge and return at the falling edge after it
  // is taken; a typed result replaces the predicted one
  task automatic send_request(req_t r, bit typed, rsp_t typed_rsp);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    apply_to_shadow(r);
    if (typed) begin
      void'(expected_rsps.pop_back());
      expected_rsps.push_back(typed_rsp);
    end
    @(negedge clk);
  endtask

  // Stall the result channel per result
  initial begin : rsp_stall
    int stall;
    rsp_ready = 1'b0;
    do @(negedge clk); while (rst);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      @(negedge clk);
    end
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d value %0d",
                                rsp.status, rsp.value));
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.status !== want.status)
          note_mismatch($sformatf("status %0d, want %0d", rsp.status, want.status));
        if (rsp.value !== want.value)
          note_mismatch($sformatf("value %0d, want %0d", rsp.value, want.value));
        if (rsp.entry_count !== want.entry_count)
          note_mismatch($sformatf("entry_count %0d, want %0d",
                                  rsp.entry_count, want.entry_count));
        if (rsp.last !== want.last)
          note_mismatch($sformatf("last %0b, want %0b", rsp.last, want.last));
      end
    end
  end

  initial begin : stimulus
    req_t r;
    int   random_count;
    int   flavor;
    int   phase_len;
    int   roll;
    int   insert_share;

    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    calm           = 1'b0;
    mismatch_count = 0;
    shadow_count   = 0;
    random_count   = 0;

    // Directed rows: empty table, unused mode, extremes, duplicates, fill to
    // full, refused insert, full dump, drain back down
    stim_rows = '{
      '{MODE_DUMP,   32'sd0,          1,  1'b1, ST_EMPTY,     5'd0},
      '{MODE_DELETE, 32'sd5,          1,  1'b1, ST_EMPTY,     5'd0},
      '{MODE_UNUSED, -32'sd1,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, KEY_MAX,         1,  1'b1, ST_INSERTED,  5'd1},
      '{MODE_INSERT, KEY_MIN,         1,  1'b1, ST_INSERTED,  5'd2},
      '{MODE_INSERT, 32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, 32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, -32'sd1,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, KEY_MIN,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DUMP,   32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, 32'sd7,          1,  1'b1, ST_NOT_FOUND, 5'd6},
      '{MODE_DELETE, 32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, KEY_MIN,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, 32'sh5555_5555,  1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, 32'shAAAA_AAAA,  1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, 32'sd100,        10, 1'b0, ST_INSERTED,  5'd0},
      '{MODE_INSERT, -32'sd7,         1,  1'b1, ST_FULL,      5'd16},
      '{MODE_DUMP,   32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, KEY_MAX,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, KEY_MIN,         1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, 32'shAAAA_AAAA,  1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, 32'sd100,        10, 1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, 32'sh5555_5555,  1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DELETE, 32'sd0,          1,  1'b0, ST_INSERTED,  5'd0},
      '{MODE_DUMP,   32'sd0,          1,  1'b0, ST_INSERTED,  5'd0}
    };

    // Hold reset, then release it on a falling edge
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Walk the directed rows
    foreach (stim_rows[i]) begin
      for (int k = 0; k < stim_rows[i].reps; k++) begin
        r.mode = stim_rows[i].mode;
        r.key  = stim_rows[i].key + k;
        send_request(r, stim_rows[i].typed,
                     make_rsp(stim_rows[i].status, r.key, stim_rows[i].count, 1'b1));
      end
    end

    // Random phases that lean toward filling, draining or neither
    while (random_count < RANDOM_ITEMS) begin
      flavor       = $urandom_range(PHASE_FILL, PHASE_MIXED);
      phase_len    = $urandom_range(10, 40);
      calm         = ($urandom_range(0, 3) == 0);
      insert_share = (flavor == PHASE_FILL) ? 70 : (flavor == PHASE_DRAIN) ? 17 : 43;
      for (int n = 0; n < phase_len && random_count < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          r.mode = MODE_UNUSED;
          r.key  = $urandom;
        end else if (roll < 14) begin
          r.mode = MODE_DUMP;
          r.key  = $urandom;
        end else if (roll < 14 + insert_share) begin
          r.mode = MODE_INSERT;
          r.key  = pick_key();
        end else begin
          r.mode = MODE_DELETE;
          r.key  = pick_stored_key();
        end
        send_request(r, 1'b0, '0);
        if (r.mode != MODE_UNUSED) random_count++;
      end
    end

    // Drain and let the block settle
    calm = 1'b0;
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/skt_pkg.sv
rtl/skt_dpath.sv
rtl/skt_ctrl.sv
rtl/sorted_key_table.sv
bench/sorted_key_table_tb.sv
